>>> rtl/rqhyp_pkg.sv
package rqhyp_pkg;

	// input transaction, one pose pair in Q1.14
	typedef struct packed {
		logic signed [15:0] head_z;
		logic signed [15:0] head_y;
		logic signed [15:0] head_x;
		logic signed [15:0] head_w;
		logic signed [15:0] chest_z;
		logic signed [15:0] chest_y;
		logic signed [15:0] chest_x;
		logic signed [15:0] chest_w;
	} pose_item_t;

	typedef enum logic [1:0] {
		REG_YAW_LIMIT   = 2'd0,
		REG_PITCH_UPPER = 2'd1,
		REG_PITCH_LOWER = 2'd2
	} cfg_reg_t;

	localparam int ITEM_W    = 128;
	localparam int OUT_W     = 32;
	localparam int ANGLE_W   = 15;
	localparam int QUAT_W    = 20;  // rounded relative quaternion component
	localparam int MAT_W     = 44;  // rotation matrix entries, Q28
	localparam int R02_W     = 30;  // saturated R02
	localparam int SQ_VW     = 57;  // radicand, up to 2^56
	localparam int SQ_RW     = 29;  // root, up to 2^28
	localparam int CW        = 48;  // rotator datapath
	localparam int COS_EPS   = 268;
	localparam int ATAN_FRAC = 30;
	localparam int ATAN_LEN  = 24;

	localparam longint ATAN_Q30 [ATAN_LEN] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	// round a Q30 angle to frac bits, half up
	function automatic longint angle_round(longint t, int frac);
		return (t + (longint'(1) <<< (ATAN_FRAC - 1 - frac))) >>> (ATAN_FRAC - frac);
	endfunction

endpackage

>>> rtl/rqhyp_queue.sv
module rqhyp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rqhyp_pkg::pose_item_t din,
	output logic                 ready,
	input  logic                 pop,
	output logic                 not_empty,
	output rqhyp_pkg::pose_item_t dout
);
	import rqhyp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	pose_item_t          mem_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [AW:0]         count_q;
	logic                do_pop;

	assign ready     = (count_q != (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rqhyp_isqrt.sv
module rqhyp_isqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rqhyp_pkg::SQ_VW-1:0]     v_in,
	input  logic [SIDE_W-1:0]               side_in,
	output logic [rqhyp_pkg::SQ_RW-1:0]     root,
	output logic [SIDE_W-1:0]               side_out
);
	import rqhyp_pkg::*;

	logic [SQ_VW-1:0]  rem_s  [0:SQ_RW];
	logic [SQ_RW-1:0]  root_s [0:SQ_RW];
	logic [SIDE_W-1:0] side_s [0:SQ_RW];

	// one result bit per stage, most significant first
	always_ff @(posedge clk) begin
		logic [SQ_VW:0] trial;
		if (en) begin
			rem_s[0]  <= v_in;
			root_s[0] <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < SQ_RW; k++) begin
				trial = ((SQ_VW+1)'(root_s[k]) << (SQ_RW - k))
				      + ((SQ_VW+1)'(1) << (2 * (SQ_RW - 1 - k)));
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial[SQ_VW-1:0];
					root_s[k+1] <= root_s[k] | (SQ_RW'(1) << (SQ_RW - 1 - k));
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign root     = root_s[SQ_RW];
	assign side_out = side_s[SQ_RW];

endmodule

>>> rtl/rqhyp_cordic.sv
module rqhyp_cordic #(
	parameter int STEPS = 14,
	parameter int FRAC  = 13
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [rqhyp_pkg::CW-1:0]   x_in,
	input  logic signed [rqhyp_pkg::CW-1:0]   y_in,
	output logic signed [FRAC+7:0]            angle
);
	import rqhyp_pkg::*;

	localparam int ZW = FRAC + 8;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(angle_round(2 * ATAN_Q30[0], FRAC));

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			// turn the left half plane into the right one
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= QUARTER;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -QUARTER;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			for (int i = 0; i < STEPS; i++) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ZW'(angle_round(ATAN_Q30[i], FRAC));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ZW'(angle_round(ATAN_Q30[i], FRAC));
				end
			end
		end
	end

	assign angle = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule

>>> rtl/relative_quat_head_yaw_pitch.sv
// Pipeline: the quaternion and matrix math (its first stage registers as the queue is read),
//   the square root, the two rotators and the output register, which drives m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls the output register; the square
//   root and both rotators are fully pipelined.
// Reset: arst_n clears the queue, the valid bits and the output valid flag and loads the
//   clamp registers with pi/2, pi/6 and -pi/9.
module relative_quat_head_yaw_pitch #(
	parameter int CORDIC_STEPS    = 14,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	// chest_w, chest_x, chest_y, chest_z, head_w, head_x, head_y, head_z (16 bits each)
	input  logic [127:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// yaw_angle [14:0], pitch_angle [29:15], zero [31:30]
	output logic [31:0]  m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data
);
	import rqhyp_pkg::*;

	localparam int ZW     = ANGLE_FRAC_BITS + 8;
	localparam int LAT    = 5 + SQ_RW + 1 + CORDIC_STEPS + 1;
	localparam int SIDE_W = R02_W + 4 * MAT_W;
	localparam logic signed [MAT_W-1:0] ONE_Q28 = MAT_W'(1) <<< 28;

	// configuration registers
	logic [13:0]        yaw_limit_q;
	logic [13:0]        pitch_upper_q;
	logic signed [14:0] pitch_lower_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_limit_q   <= 14'd12868;
			pitch_upper_q <= 14'd4289;
			pitch_lower_q <= -15'sd2859;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_YAW_LIMIT:   yaw_limit_q   <= cfg_data[13:0];
				REG_PITCH_UPPER: pitch_upper_q <= cfg_data[13:0];
				REG_PITCH_LOWER: pitch_lower_q <= cfg_data;
				default:         ; // drop writes beyond the register list
			endcase
		end
	end

	// front: accept transactions into a short queue
	pose_item_t in_item;
	pose_item_t q_item;
	logic       q_not_empty;
	logic       en;
	logic       pop;

	assign in_item.chest_w = s_tdata[15:0];
	assign in_item.chest_x = s_tdata[31:16];
	assign in_item.chest_y = s_tdata[47:32];
	assign in_item.chest_z = s_tdata[63:48];
	assign in_item.head_w  = s_tdata[79:64];
	assign in_item.head_x  = s_tdata[95:80];
	assign in_item.head_y  = s_tdata[111:96];
	assign in_item.head_z  = s_tdata[127:112];

	rqhyp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.din       (in_item),
		.ready     (s_tready),
		.pop       (pop),
		.not_empty (q_not_empty),
		.dout      (q_item)
	);

	// back: the whole pipe advances unless the output register holds a result nobody takes
	logic           out_valid_q;
	logic [LAT-1:0] vld_q;

	assign en  = !out_valid_q || m_tready;
	assign pop = en && q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], q_not_empty};
		end
	end

	// stage 1: all sixteen chest by head products
	logic signed [15:0] cq [4];
	logic signed [15:0] hq [4];
	logic signed [31:0] prod_s1 [4][4];

	assign cq[0] = q_item.chest_w;
	assign cq[1] = q_item.chest_x;
	assign cq[2] = q_item.chest_y;
	assign cq[3] = q_item.chest_z;
	assign hq[0] = q_item.head_w;
	assign hq[1] = q_item.head_x;
	assign hq[2] = q_item.head_y;
	assign hq[3] = q_item.head_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= cq[i] * hq[j];
				end
			end
		end
	end

	// stage 2: conj(chest) * head, rounded half up to Q14
	logic signed [33:0] sw, sx, sy, sz;
	logic signed [QUAT_W-1:0] w_s2, x_s2, y_s2, z_s2;

	always_comb begin
		sw = 34'(prod_s1[0][0]) + 34'(prod_s1[1][1]) + 34'(prod_s1[2][2])
		   + 34'(prod_s1[3][3]) + 34'sd8192;
		sx = 34'(prod_s1[0][1]) - 34'(prod_s1[1][0]) - 34'(prod_s1[2][3])
		   + 34'(prod_s1[3][2]) + 34'sd8192;
		sy = 34'(prod_s1[0][2]) + 34'(prod_s1[1][3]) - 34'(prod_s1[2][0])
		   - 34'(prod_s1[3][1]) + 34'sd8192;
		sz = 34'(prod_s1[0][3]) - 34'(prod_s1[1][2]) + 34'(prod_s1[2][1])
		   - 34'(prod_s1[3][0]) + 34'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= sw[33:14];
			x_s2 <= sx[33:14];
			y_s2 <= sy[33:14];
			z_s2 <= sz[33:14];
		end
	end

	// stage 3: component products for the matrix entries
	logic signed [39:0] xz_s3, wy_s3, yz_s3, wx_s3, xx_s3, yy_s3, xy_s3, wz_s3, zz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			xz_s3 <= x_s2 * z_s2;
			wy_s3 <= w_s2 * y_s2;
			yz_s3 <= y_s2 * z_s2;
			wx_s3 <= w_s2 * x_s2;
			xx_s3 <= x_s2 * x_s2;
			yy_s3 <= y_s2 * y_s2;
			xy_s3 <= x_s2 * y_s2;
			wz_s3 <= w_s2 * z_s2;
			zz_s3 <= z_s2 * z_s2;
		end
	end

	// stage 4: matrix entries in Q28, R02 saturated to plus or minus one
	logic signed [MAT_W-1:0] r02_full;
	logic signed [R02_W-1:0] r02_s4;
	logic signed [MAT_W-1:0] r12_s4, r22_s4, r10_s4, r11_s4;

	assign r02_full = (MAT_W'(xz_s3) + MAT_W'(wy_s3)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (r02_full > ONE_Q28) begin
				r02_s4 <= R02_W'(ONE_Q28);
			end else if (r02_full < -ONE_Q28) begin
				r02_s4 <= -R02_W'(ONE_Q28);
			end else begin
				r02_s4 <= r02_full[R02_W-1:0];
			end
			r12_s4 <= (MAT_W'(yz_s3) - MAT_W'(wx_s3)) <<< 1;
			r22_s4 <= ONE_Q28 - ((MAT_W'(xx_s3) + MAT_W'(yy_s3)) <<< 1);
			r10_s4 <= (MAT_W'(xy_s3) + MAT_W'(wz_s3)) <<< 1;
			r11_s4 <= ONE_Q28 - ((MAT_W'(xx_s3) + MAT_W'(zz_s3)) <<< 1);
		end
	end

	// stage 5: square of R02
	logic signed [2*R02_W-1:0] sq_full;
	logic [SQ_VW-1:0]          sq_s5;
	logic signed [R02_W-1:0]   r02_s5;
	logic signed [MAT_W-1:0]   r12_s5, r22_s5, r10_s5, r11_s5;

	assign sq_full = r02_s4 * r02_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5  <= sq_full[SQ_VW-1:0];
			r02_s5 <= r02_s4;
			r12_s5 <= r12_s4;
			r22_s5 <= r22_s4;
			r10_s5 <= r10_s4;
			r11_s5 <= r11_s4;
		end
	end

	// cos(yaw) = floor(sqrt(2^56 - R02^2)), other entries ride alongside
	logic [SQ_VW-1:0]  radicand;
	logic [SQ_RW-1:0]  cos_y;
	logic [SIDE_W-1:0] side_out;

	assign radicand = (SQ_VW'(1) << 56) - sq_s5;

	rqhyp_isqrt #(
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.v_in     (radicand),
		.side_in  ({r02_s5, r12_s5, r22_s5, r10_s5, r11_s5}),
		.root     (cos_y),
		.side_out (side_out)
	);

	logic signed [R02_W-1:0] r02_q;
	logic signed [MAT_W-1:0] r12_q, r22_q, r10_q, r11_q;
	logic                    normal;
	logic signed [CW-1:0]    pitch_x, pitch_y;

	assign {r02_q, r12_q, r22_q, r10_q, r11_q} = side_out;

	// near cos(yaw) = 0 take pitch from the gimbal-lock branch
	assign normal  = cos_y > SQ_RW'(COS_EPS);
	assign pitch_y = normal ? -CW'(r12_q) : CW'(r10_q);
	assign pitch_x = normal ? CW'(r22_q) : CW'(r11_q);

	logic signed [ZW-1:0] yaw_z, pitch_z;

	rqhyp_cordic #(
		.STEPS (CORDIC_STEPS),
		.FRAC  (ANGLE_FRAC_BITS)
	) u_cordic_yaw (
		.clk   (clk),
		.en    (en),
		.x_in  (CW'(cos_y)),
		.y_in  (CW'(r02_q)),
		.angle (yaw_z)
	);

	rqhyp_cordic #(
		.STEPS (CORDIC_STEPS),
		.FRAC  (ANGLE_FRAC_BITS)
	) u_cordic_pitch (
		.clk   (clk),
		.en    (en),
		.x_in  (pitch_x),
		.y_in  (pitch_y),
		.angle (pitch_z)
	);

	// clamp: yaw symmetric; pitch lower bound first, upper bound wins
	logic signed [ZW-1:0] ylim, pup, plo, yaw_c, pitch_c, pitch_lo;

	assign ylim = {{(ZW-14){1'b0}}, yaw_limit_q};
	assign pup  = {{(ZW-14){1'b0}}, pitch_upper_q};
	assign plo  = {{(ZW-15){pitch_lower_q[14]}}, pitch_lower_q};

	always_comb begin
		priority if (yaw_z > ylim) begin
			yaw_c = ylim;
		end else if (yaw_z < -ylim) begin
			yaw_c = -ylim;
		end else begin
			yaw_c = yaw_z;
		end
		pitch_lo = (pitch_z < plo) ? plo : pitch_z;
		pitch_c  = (pitch_lo > pup) ? pup : pitch_lo;
	end

	// output register: hold the result until the transaction completes
	logic [ANGLE_W-1:0] yaw_q, pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_q   <= yaw_c[ANGLE_W-1:0];
			pitch_q <= pitch_c[ANGLE_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, pitch_q, yaw_q};

endmodule

>>> rtl/rqhyp_checker.sv
module rqhyp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic [127:0] s_tdata,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [31:0]  m_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [1:0]   cfg_index,
	input logic [14:0]  cfg_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// padding above the two angles stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("output padding not zero");

	// no result straight out of reset
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid after reset");

	// the queue is empty right after reset and takes a transaction
	a_rdy: assert property (@(posedge clk)
		$rose(arst_n) |-> s_tready)
		else $error("input not ready after reset");

endmodule

bind relative_quat_head_yaw_pitch rqhyp_checker u_chk (.*);
